@@ sv/nalsc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsc_pkg
// Shared types and constants of the NAL start code scanner.
// ----------------------------------------------------------------------------
package nalsc_pkg;

  localparam int unsigned OUT_W    = 32;
  localparam int unsigned TYPE_W   = 5;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned HIST_W   = 4 * BYTE_W;
  localparam int unsigned RES_W    = TYPE_W + 3 * OUT_W;
  localparam int unsigned TDATA_W  = ((RES_W + 7) / 8) * 8;
  localparam int unsigned PAD_W    = TDATA_W - RES_W;

  localparam logic [HIST_W-1:0] START_CODE = 32'h0000_0001;
  localparam logic [HIST_W-1:0] HIST_RESET = 32'hFFFF_FFFF;
  localparam logic [OUT_W-1:0]  OUT_MAX    = 32'hFFFF_FFFF;
  localparam logic [2:0]        CODE_LEN   = 3'd4;

  typedef struct packed {
    logic              prev_valid;
    logic [OUT_W-1:0]  prev_size;
    logic [OUT_W-1:0]  nal_index;
    logic [OUT_W-1:0]  nal_offset;
    logic [TYPE_W-1:0] nal_type;
  } nalsc_res_t;

endpackage

@@ sv/nalsc_tracker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsc_tracker
// Four-byte window match plus position, unit count and previous-unit state.
// ----------------------------------------------------------------------------
module nalsc_tracker import nalsc_pkg::*; #(
  parameter int unsigned POS_BITS = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] data_byte_i,
  input  logic              last_byte_i,
  output logic              hit_o,
  output nalsc_res_t        res_o
);

  localparam int unsigned EXT_W = (POS_BITS + 1 > OUT_W + 1) ? POS_BITS + 1 : OUT_W + 1;

  logic [HIST_W-1:0]   hist_q, hist_d;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic [POS_BITS:0]   lus4_q, lus4_d;   // previous header position + 4
  logic                have_q, have_d;
  logic [OUT_W-1:0]    units_q, units_d;

  logic [POS_BITS:0] pos_x;
  logic [POS_BITS:0] diff;
  logic [EXT_W-1:0]  diff_ext;
  logic [EXT_W-1:0]  pos_ext;
  logic              diff_ge;

  assign hit_o = (hist_q == START_CODE);

  assign pos_x    = {1'b0, pos_q};
  assign diff_ge  = (pos_x >= lus4_q);
  assign diff     = pos_x - lus4_q;
  assign diff_ext = EXT_W'(diff);
  assign pos_ext  = EXT_W'(pos_q);

  always_comb begin
    res_o.nal_type   = data_byte_i[TYPE_W-1:0];
    res_o.nal_offset = (pos_ext > EXT_W'(OUT_MAX)) ? OUT_MAX : pos_ext[OUT_W-1:0];
    res_o.nal_index  = units_q;
    res_o.prev_valid = have_q;
    if (!have_q || !diff_ge) begin
      res_o.prev_size = '0;
    end else if (diff_ext > EXT_W'(OUT_MAX)) begin
      res_o.prev_size = OUT_MAX;
    end else begin
      res_o.prev_size = diff_ext[OUT_W-1:0];
    end
  end

  always_comb begin
    hist_d  = {hist_q[HIST_W-BYTE_W-1:0], data_byte_i};
    pos_d   = (&pos_q) ? pos_q : pos_q + POS_BITS'(1);
    lus4_d  = lus4_q;
    have_d  = have_q;
    units_d = units_q;
    if (hit_o) begin
      lus4_d  = pos_x + (POS_BITS + 1)'(CODE_LEN);
      have_d  = 1'b1;
      units_d = (&units_q) ? units_q : units_q + OUT_W'(1);
    end
    // end of buffer: back to reset state
    if (last_byte_i) begin
      hist_d  = HIST_RESET;
      pos_d   = '0;
      lus4_d  = (POS_BITS + 1)'(CODE_LEN);
      have_d  = 1'b0;
      units_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q  <= HIST_RESET;
      pos_q   <= '0;
      lus4_q  <= (POS_BITS + 1)'(CODE_LEN);
      have_q  <= 1'b0;
      units_q <= '0;
    end else if (accept_i) begin
      hist_q  <= hist_d;
      pos_q   <= pos_d;
      lus4_q  <= lus4_d;
      have_q  <= have_d;
      units_q <= units_d;
    end
  end

endmodule

@@ sv/nal_start_code_scanner_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_start_code_scanner_core
// Annex B start code scanner: reports each NAL unit's type, offset, index
// and the size of the unit before it.
// ----------------------------------------------------------------------------
// The result is registered and appears in the cycle after its header byte is accepted.
// Throughput: one byte per cycle; set by the single output register, which
//   stalls input only while it holds a result the sink has not taken.
// Reset: asynchronous, active low; clears the byte window, position, unit
//   count and output valid. tlast on an accepted byte clears all but output valid.
// ----------------------------------------------------------------------------
module nal_start_code_scanner_core import nalsc_pkg::*; #(
  parameter int unsigned POS_BITS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input byte stream
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] data_byte
  input  logic               s_axis_tlast_i,   // last_byte
  // unit reports
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [4:0] nal_type, [36:5] nal_offset, [68:37] nal_index,
  // [100:69] prev_size, [103:101] zero
  output logic [TDATA_W-1:0] m_axis_tdata_o,
  output logic               m_axis_tuser_o    // prev_valid
);

  logic       in_acc;
  logic       hit;
  nalsc_res_t res;

  logic       out_valid_q;
  nalsc_res_t res_q;

  // Input is taken whenever the output register is free or being drained
  // in the same cycle; a waiting result blocks input only while the sink stalls.
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Window compare and all per-stream counters live in the tracker.
  nalsc_tracker #(
    .POS_BITS (POS_BITS)
  ) u_tracker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (in_acc),
    .data_byte_i (s_axis_tdata_i),
    .last_byte_i (s_axis_tlast_i),
    .hit_o       (hit),
    .res_o       (res)
  );

  // Result register: loaded when the byte after a start code is taken,
  // released when the sink accepts the transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && hit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk_i) begin
    if (in_acc && hit) begin
      res_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{PAD_W{1'b0}}, res_q.prev_size, res_q.nal_index,
                            res_q.nal_offset, res_q.nal_type};
  assign m_axis_tuser_o  = res_q.prev_valid;

endmodule

@@ sv/nalsc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nalsc_checker
// Port-level checks of the NAL start code scanner.
// ----------------------------------------------------------------------------
module nalsc_checker import nalsc_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               s_axis_tready_o,
  input logic               m_axis_tvalid_o,
  input logic               m_axis_tready_i,
  input logic [TDATA_W-1:0] m_axis_tdata_o,
  input logic               m_axis_tuser_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // with no pending result the input side must be open
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input blocked with empty output register");

  // no previous unit means zero size
  a_size_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |-> m_axis_tdata_o[100:69] == '0)
    else $error("prev_size set without previous unit");

  // first unit of a buffer has no predecessor
  a_first_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[68:37] == '0 |-> !m_axis_tuser_o)
    else $error("first unit flagged with previous unit");

endmodule

bind nal_start_code_scanner_core nalsc_checker u_nalsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

@@ tb/nal_start_code_scanner_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nal_start_code_scanner_core_test
// Self-checking bench for the Annex B start code scanner. A short table of
// directed bytes comes first. Then come random buffers of start codes,
// headers and payload, with broken codes and noise mixed in. Each accepted
// byte goes through a local scan model. Each unit report the block sends is
// compared field by field, in order, with the oldest pending prediction.
// ----------------------------------------------------------------------------
module nal_start_code_scanner_core_test;
  import nalsc_pkg::*;

  localparam int unsigned POS_BITS     = 32;
  localparam int unsigned RANDOM_ITEMS = 700;

  // One byte to feed. Table rows may carry a typed-in expected report.
  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
    bit                typed;
    bit                hit;
    nalsc_res_t        report;
  } feed_byte_t;

  logic               clk_i           = 1'b0;
  logic               rst_ni          = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i  = '0;
  logic               s_axis_tlast_i  = 1'b0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [TDATA_W-1:0] m_axis_tdata_o;
  logic               m_axis_tuser_o;

  feed_byte_t offered;              // byte currently on the input bus
  feed_byte_t byte_feed[$];
  nalsc_res_t expected_units[$];
  int         errors = 0;

  // scan model state
  logic [HIST_W-1:0]   win_hist;
  logic [POS_BITS-1:0] win_pos;
  logic [POS_BITS-1:0] unit_start;
  logic                have_unit;
  logic [OUT_W-1:0]    unit_count;

  nal_start_code_scanner_core #(
    .POS_BITS(POS_BITS)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void clear_scan_state();
    win_hist   = HIST_RESET;
    win_pos    = '0;
    unit_start = '0;
    have_unit  = 1'b0;
    unit_count = '0;
  endfunction

  // Advances the scan model by one byte; returns 1 when a unit is reported.
  function automatic bit scan_byte(input logic [BYTE_W-1:0] b, input logic last,
                                   output nalsc_res_t rep);
    logic [POS_BITS-1:0] span;
    logic [POS_BITS-1:0] gap;
    bit                  found;
    found = 1'b0;
    rep   = '0;
    if (win_hist == START_CODE) begin
      found          = 1'b1;
      rep.nal_type   = b[TYPE_W-1:0];
      rep.nal_offset = (win_pos > OUT_MAX) ? OUT_MAX : OUT_W'(win_pos);
      rep.nal_index  = unit_count;
      if (have_unit) begin
        span          = (win_pos >= unit_start) ? win_pos - unit_start : '0;
        gap           = (span >= CODE_LEN) ? span - CODE_LEN : '0;
        rep.prev_size = (gap > OUT_MAX) ? OUT_MAX : OUT_W'(gap);
        rep.prev_valid = 1'b1;
      end
      if (unit_count != OUT_MAX) unit_count++;
      unit_start = win_pos;
      have_unit  = 1'b1;
    end
    win_hist = {win_hist[HIST_W-BYTE_W-1:0], b};
    if (win_pos != '1) win_pos++;
    if (last) clear_scan_state();
    return found;
  endfunction

  function automatic void add_row(logic [7:0] data, logic last, bit typed, bit hit,
                                  logic [TYPE_W-1:0] ntype, logic [OUT_W-1:0] offset,
                                  logic [OUT_W-1:0] index, logic [OUT_W-1:0] psize,
                                  logic pvalid);
    feed_byte_t fb;
    fb.data              = data;
    fb.last              = last;
    fb.typed             = typed;
    fb.hit               = hit;
    fb.report.nal_type   = ntype;
    fb.report.nal_offset = offset;
    fb.report.nal_index  = index;
    fb.report.prev_size  = psize;
    fb.report.prev_valid = pvalid;
    byte_feed.push_back(fb);
  endfunction

  function automatic void add_byte(logic [7:0] data, logic last);
    add_row(data, last, 0, 0, '0, '0, '0, '0, 1'b0);
  endfunction

  // Directed table; rows with typed = 0 are checked by the scan model.
  //        data   last typ hit type  offset index psize pv
  function automatic void build_directed();
    // first unit after reset, all-ones header
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h01, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'hFF, 0, 1, 1, 5'h1F, 4, 0, 0, 0);
    // second unit, directly after the first unit's header byte
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h01, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'hE0, 0, 1, 1, 5'h00, 9, 1, 1, 1);
    // three-byte code is not a start code
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h01, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h05, 0, 1, 0, 5'h00, 0, 0, 0, 0);
    // extra leading zero before the code
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h01, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h07, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    // code ending on the buffer's final byte: dropped, state cleared
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h01, 1, 1, 0, 5'h00, 0, 0, 0, 0);
    // fresh buffer whose final byte is itself a header
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h00, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h01, 0, 0, 0, 5'h00, 0, 0, 0, 0);
    add_row(8'h41, 1, 1, 1, 5'h01, 4, 0, 0, 0);
  endfunction

  // payload biased toward zeros and ones to form near-miss codes
  function automatic logic [7:0] payload_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'h01;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic void push_buffer(ref logic [7:0] bytes[$]);
    foreach (bytes[i]) add_byte(bytes[i], i == bytes.size() - 1);
  endfunction

  // Mostly well-formed buffers of units, some noise buffers and broken codes.
  function automatic void build_random();
    logic [7:0] bytes[$];
    int         stop;
    int         units;
    int         plen;
    stop = byte_feed.size() + RANDOM_ITEMS;
    while (byte_feed.size() < stop) begin
      bytes.delete();
      if ($urandom_range(0, 9) == 0) begin
        plen = $urandom_range(1, 24);
        repeat (plen) bytes.push_back(payload_byte());
      end else begin
        units = $urandom_range(1, 6);
        repeat (units) begin
          case ($urandom_range(0, 11))
            0:       bytes = {bytes, 8'h00, 8'h00, 8'h01};
            1:       bytes = {bytes, 8'h00, 8'h00, 8'h00, 8'h02};
            2:       bytes = {bytes, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
            default: bytes = {bytes, 8'h00, 8'h00, 8'h00, 8'h01};
          endcase
          bytes.push_back(8'($urandom_range(0, 255)));
          plen = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          repeat (plen) bytes.push_back(payload_byte());
        end
        // sometimes the buffer ends on a start code with no header
        if ($urandom_range(0, 7) == 0) bytes = {bytes, 8'h00, 8'h00, 8'h00, 8'h01};
      end
      push_buffer(bytes);
    end
  endfunction

  function automatic void check_field(string name, logic [OUT_W-1:0] want,
                                      logic [OUT_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      errors++;
    end
  endfunction

  // Input transactions feed the scan model.
  always @(posedge clk_i) begin : predict_units
    nalsc_res_t rep;
    bit         found;
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      found = scan_byte(offered.data, offered.last, rep);
      if (offered.typed) begin
        if (offered.hit) expected_units.push_back(offered.report);
      end else if (found) begin
        expected_units.push_back(rep);
      end
    end
  end

  // Output transactions are compared with the oldest prediction.
  always @(posedge clk_i) begin : check_units
    nalsc_res_t want;
    nalsc_res_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = {m_axis_tuser_o, m_axis_tdata_o[RES_W-1:0]};
      if (expected_units.size() == 0) begin
        $error("unit report with none expected: tdata 0x%0h", m_axis_tdata_o);
        errors++;
      end else begin
        want = expected_units.pop_front();
        check_field("nal_type",   OUT_W'(want.nal_type),   OUT_W'(got.nal_type));
        check_field("nal_offset", want.nal_offset, got.nal_offset);
        check_field("nal_index",  want.nal_index,  got.nal_index);
        check_field("prev_size",  want.prev_size,  got.prev_size);
        check_field("prev_valid", OUT_W'(want.prev_valid), OUT_W'(got.prev_valid));
        check_field("tdata pad",  '0, OUT_W'(m_axis_tdata_o[TDATA_W-1:RES_W]));
      end
    end
  end

  task automatic send_bytes();
    feed_byte_t fb;
    int         gap;
    int         sent;
    bit         burst;
    sent  = 0;
    burst = 1'b0;
    while (byte_feed.size() != 0) begin
      fb = byte_feed.pop_front();
      if (sent % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      gap = burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        s_axis_tvalid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      s_axis_tvalid_i <= 1'b1;
      s_axis_tdata_i  <= fb.data;
      s_axis_tlast_i  <= fb.last;
      offered         <= fb;
      do @(posedge clk_i); while (!s_axis_tready_o);
      sent++;
    end
    s_axis_tvalid_i <= 1'b0;
    s_axis_tlast_i  <= 1'b0;
  endtask

  // Sink with random stalls; twice it holds off long enough to back up input.
  task automatic take_units();
    int gap;
    int taken;
    bit burst;
    taken = 0;
    burst = 1'b0;
    forever begin
      if (taken % 32 == 0) burst = ($urandom_range(0, 3) == 0);
      if (taken == 10 || taken == 40) gap = 80;
      else gap = burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      taken++;
    end
  endtask

  initial begin
    clear_scan_state();
    build_directed();
    build_random();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    fork
      take_units();
    join_none
    send_bytes();
    while (expected_units.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #500_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
